FILE: rtl/tmb_pkg.sv
// Shared types, codes and constants of the tiled midpoint binarizer.
package tmb_pkg;

	localparam int CFG_WIDTH   = 13;
	localparam int CFG_INDEX_W = 1;

	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [CFG_WIDTH-1:0] FRAME_WIDTH_RESET  = 13'd640;
	localparam logic [CFG_WIDTH-1:0] FRAME_HEIGHT_RESET = 13'd480;

	localparam logic OP_MEASURE   = 1'b0;
	localparam logic OP_THRESHOLD = 1'b1;

	localparam int SUM_W      = 15;
	localparam int PROD_W     = 28;
	localparam int WEIGHT_RB  = 33;
	localparam int WEIGHT_G   = 34;
	localparam int GRAY_RECIP = 5243;
	localparam int GRAY_SHIFT = 19;

	localparam logic [7:0] MIN_RESET = 8'hff;
	localparam logic [7:0] MAX_RESET = 8'h00;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUM,
		ST_MUL,
		ST_APPLY
	} tmb_state_t;

	typedef struct packed {
		logic capture;
		logic sum;
		logic mul;
		logic apply;
	} tmb_cmd_t;

	typedef struct packed {
		logic threshold;
		logic out_busy;
	} tmb_stat_t;

endpackage

FILE: rtl/tmb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tmb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/tmb_ctrl.sv
// Controller state machine sequencing one pixel word through the datapath.
module tmb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tmb_pkg::tmb_stat_t  stat,
	output tmb_pkg::tmb_cmd_t   cmd
);

	tmb_pkg::tmb_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tmb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_ready    = 1'b0;
		unique case (state_q)
			tmb_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = tmb_pkg::ST_SUM;
				end
			end
			tmb_pkg::ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = tmb_pkg::ST_MUL;
			end
			tmb_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = tmb_pkg::ST_APPLY;
			end
			tmb_pkg::ST_APPLY: begin
				if (!(stat.threshold && stat.out_busy)) begin
					cmd.apply = 1'b1;
					state_d   = tmb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tmb_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/tmb_datapath.sv
// Datapath: config registers, gray conversion, tile store, position counters, output word.
module tmb_datapath #(
	parameter int TILES_PER_SIDE = 4,
	parameter int MAX_SIDE       = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [tmb_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [tmb_pkg::CFG_WIDTH-1:0]        cfg_data,
	input  logic                                 operation,
	input  logic [7:0]                           red,
	input  logic [7:0]                           green,
	input  logic [7:0]                           blue,
	input  tmb_pkg::tmb_cmd_t                    cmd,
	output tmb_pkg::tmb_stat_t                   stat,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 dark,
	output logic                                 last_pixel
);

	localparam int T      = TILES_PER_SIDE;
	localparam int TILE_N = T * T;
	localparam int IW     = (TILE_N > 1) ? $clog2(TILE_N) : 1;
	localparam int SW     = $clog2(MAX_SIDE + 1);
	localparam int CNTW   = $clog2(MAX_SIDE);
	localparam int CW     = (SW > tmb_pkg::CFG_WIDTH) ? SW : tmb_pkg::CFG_WIDTH;
	localparam int TCW    = $clog2(T + 1);
	localparam int PW     = SW + TCW + 1;
	localparam int XW     = 2 * TCW + 1;

	function automatic logic [SW-1:0] clamp_side(input logic [tmb_pkg::CFG_WIDTH-1:0] v);
		logic [CW-1:0] e;
		logic [CW-1:0] c;
		e = CW'(v);
		if (e == '0) begin
			c = CW'(1);
		end else if (e > CW'(MAX_SIDE)) begin
			c = CW'(MAX_SIDE);
		end else begin
			c = e;
		end
		return c[SW-1:0];
	endfunction

	logic [tmb_pkg::CFG_WIDTH-1:0] frame_width_q, frame_height_q;

	logic                  op_q;
	logic [7:0]            red_q, green_q, blue_q;
	logic [tmb_pkg::SUM_W-1:0] sum_s1;
	logic [7:0]            gray_s2;
	logic [tmb_pkg::PROD_W-1:0] prod;

	logic [CNTW-1:0] col_q, row_q, cit_q, rit_q;
	logic [TCW-1:0]  tc_q, tr_q;
	logic [TILE_N-1:0] valid_q;

	logic            out_valid_q, dark_q, last_q;

	logic [SW-1:0]   side_w, side_h;
	logic            row_end, frame_end, cit_wrap, rit_wrap, in_grid, clear;
	logic [XW-1:0]   idx_full;
	logic [IW-1:0]   idx;
	logic [15:0]     rdata;
	logic [7:0]      cur_min, cur_max, new_min, new_max;
	logic [8:0]      mid_sum;
	logic            ram_we;

	assign side_w    = clamp_side(frame_width_q);
	assign side_h    = clamp_side(frame_height_q);
	assign row_end   = (SW'(col_q) + SW'(1)) >= side_w;
	assign frame_end = row_end && ((SW'(row_q) + SW'(1)) >= side_h);
	assign cit_wrap  = PW'(side_w) < ((PW'(cit_q) + PW'(2)) * PW'(T));
	assign rit_wrap  = PW'(side_h) < ((PW'(rit_q) + PW'(2)) * PW'(T));
	assign in_grid   = (side_w >= SW'(T)) && (side_h >= SW'(T)) &&
	                   (tc_q < TCW'(T)) && (tr_q < TCW'(T));
	assign idx_full  = in_grid ? (XW'(tr_q) * XW'(T) + XW'(tc_q)) : '0;
	assign idx       = idx_full[IW-1:0];
	assign clear     = (op_q == tmb_pkg::OP_MEASURE) && (col_q == '0) && (row_q == '0);

	assign cur_min = (clear || !valid_q[idx]) ? tmb_pkg::MIN_RESET : rdata[15:8];
	assign cur_max = (clear || !valid_q[idx]) ? tmb_pkg::MAX_RESET : rdata[7:0];
	assign new_min = (gray_s2 < cur_min) ? gray_s2 : cur_min;
	assign new_max = (gray_s2 > cur_max) ? gray_s2 : cur_max;
	assign mid_sum = {1'b0, cur_min} + {1'b0, cur_max};
	assign ram_we  = cmd.apply && (op_q == tmb_pkg::OP_MEASURE) && in_grid;

	assign prod = tmb_pkg::PROD_W'(sum_s1) * tmb_pkg::PROD_W'(tmb_pkg::GRAY_RECIP);

	tmb_ram #(
		.WIDTH (16),
		.DEPTH (TILE_N)
	) u_tiles (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx),
		.wdata ({new_min, new_max}),
		.re    (cmd.mul),
		.raddr (idx),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= tmb_pkg::FRAME_WIDTH_RESET;
			frame_height_q <= tmb_pkg::FRAME_HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tmb_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				tmb_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= operation;
			red_q   <= red;
			green_q <= green;
			blue_q  <= blue;
		end
		if (cmd.sum) begin
			sum_s1 <= tmb_pkg::SUM_W'(tmb_pkg::WEIGHT_RB) * tmb_pkg::SUM_W'(red_q)
			        + tmb_pkg::SUM_W'(tmb_pkg::WEIGHT_G) * tmb_pkg::SUM_W'(green_q)
			        + tmb_pkg::SUM_W'(tmb_pkg::WEIGHT_RB) * tmb_pkg::SUM_W'(blue_q);
		end
		if (cmd.mul) begin
			gray_s2 <= prod[tmb_pkg::GRAY_SHIFT+7:tmb_pkg::GRAY_SHIFT];
		end
		if (cmd.apply && op_q == tmb_pkg::OP_THRESHOLD) begin
			dark_q <= in_grid && ({1'b0, gray_s2} < {1'b0, mid_sum[8:1]});
			last_q <= frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			cit_q       <= '0;
			rit_q       <= '0;
			tc_q        <= '0;
			tr_q        <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.apply && op_q == tmb_pkg::OP_THRESHOLD) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.apply) begin
				valid_q <= (clear ? '0 : valid_q) | (ram_we ? (TILE_N'(1) << idx) : '0);
				if (row_end) begin
					col_q <= '0;
					cit_q <= '0;
					tc_q  <= '0;
					if (frame_end) begin
						row_q <= '0;
						rit_q <= '0;
						tr_q  <= '0;
					end else begin
						row_q <= row_q + CNTW'(1);
						if (rit_wrap) begin
							rit_q <= '0;
							if (tr_q < TCW'(T)) begin
								tr_q <= tr_q + TCW'(1);
							end
						end else begin
							rit_q <= rit_q + CNTW'(1);
						end
					end
				end else begin
					col_q <= col_q + CNTW'(1);
					if (cit_wrap) begin
						cit_q <= '0;
						if (tc_q < TCW'(T)) begin
							tc_q <= tc_q + TCW'(1);
						end
					end else begin
						cit_q <= cit_q + CNTW'(1);
					end
				end
			end
		end
	end

	assign stat.threshold = (op_q == tmb_pkg::OP_THRESHOLD);
	assign stat.out_busy  = out_valid_q && !out_ready;
	assign out_valid      = out_valid_q;
	assign dark           = dark_q;
	assign last_pixel     = last_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply && op_q == tmb_pkg::OP_THRESHOLD |-> !(out_valid_q && !out_ready))
		else $error("result word overwritten while waiting");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply && op_q == tmb_pkg::OP_THRESHOLD |=> out_valid_q)
		else $error("threshold word not presented");

	a_measure_silent: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply && op_q == tmb_pkg::OP_MEASURE && !out_valid_q |=> !out_valid_q)
		else $error("measure word produced a result");

	a_tile_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		tc_q <= TCW'(T) && tr_q <= TCW'(T))
		else $error("tile position past grid");

endmodule

FILE: rtl/tiled_midpoint_binarizer_unit.sv
// Top level of the tiled midpoint binarizer: controller plus datapath.
//
//  channel   direction  handshake             payload
//  in        input      in_valid / in_ready   operation, red, green, blue
//  out       output     out_valid / out_ready dark, last_pixel
//  cfg       input      cfg_we                cfg_index, cfg_data
//
// Each pixel word goes through accept, weighted sum, reciprocal multiply
// with tile store read, then tile update or threshold compare.
// The next word is accepted while a result word waits in the output register;
// a threshold word stalls in APPLY only while the waiting word is not taken.
// Reset clears the counters and the tile valid bits; no clearing pass is needed.
module tiled_midpoint_binarizer_unit #(
	parameter int TILES_PER_SIDE = 4,
	parameter int MAX_SIDE       = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tmb_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [tmb_pkg::CFG_WIDTH-1:0]    cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             operation,
	input  logic [7:0]                       red,
	input  logic [7:0]                       green,
	input  logic [7:0]                       blue,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             dark,
	output logic                             last_pixel
);

	tmb_pkg::tmb_cmd_t  cmd;
	tmb_pkg::tmb_stat_t stat;

	tmb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tmb_datapath #(
		.TILES_PER_SIDE (TILES_PER_SIDE),
		.MAX_SIDE       (MAX_SIDE)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.operation  (operation),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.dark       (dark),
		.last_pixel (last_pixel)
	);

endmodule

FILE: bench/binarizer_checker.sv
// Result checker for the tiled midpoint binarizer: tracks frame position and tile statistics.
module binarizer_checker #(
	parameter int GRID       = 4,
	parameter int SIDE_LIMIT = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tmb_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [tmb_pkg::CFG_WIDTH-1:0]    cfg_data,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic                             operation,
	input  logic [7:0]                       red,
	input  logic [7:0]                       green,
	input  logic [7:0]                       blue,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic                             dark,
	input  logic                             last_pixel,
	output int                               mismatches,
	output int                               outstanding
);

	typedef struct packed {
		logic dark;
		logic last_pixel;
	} pixel_verdict_t;

	pixel_verdict_t verdict_q[$];
	pixel_verdict_t want;

	logic [tmb_pkg::CFG_WIDTH-1:0] width_reg;
	logic [tmb_pkg::CFG_WIDTH-1:0] height_reg;
	int unsigned col_pos, row_pos, col_in_tile, tile_col, row_in_tile, tile_row;
	logic [7:0] tile_lo [GRID*GRID];
	logic [7:0] tile_hi [GRID*GRID];
	int errors_seen = 0;
	int words_checked = 0;

	assign mismatches = errors_seen;

	function automatic int unsigned usable_side(logic [tmb_pkg::CFG_WIDTH-1:0] v);
		if (v == 0)
			return 1;
		if (v > SIDE_LIMIT)
			return SIDE_LIMIT;
		return v;
	endfunction

	function automatic void clear_tile_stats();
		for (int i = 0; i < GRID*GRID; i++) begin
			tile_lo[i] = tmb_pkg::MIN_RESET;
			tile_hi[i] = tmb_pkg::MAX_RESET;
		end
	endfunction

	function automatic void binarize(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int unsigned w, h, span_w, span_h, gray, mid, slot;
		bit in_grid, row_end, frame_end;
		pixel_verdict_t v;
		w = usable_side(width_reg);
		h = usable_side(height_reg);
		span_w = w / GRID;
		span_h = h / GRID;
		gray = (tmb_pkg::WEIGHT_RB * int'(r) + tmb_pkg::WEIGHT_G * int'(g)
			+ tmb_pkg::WEIGHT_RB * int'(b)) / 100;
		in_grid = span_w > 0 && span_h > 0 && tile_col < GRID && tile_row < GRID;
		slot = in_grid ? tile_row * GRID + tile_col : 0;
		row_end = col_pos + 1 >= w;
		frame_end = row_end && (row_pos + 1 >= h);
		if (op == tmb_pkg::OP_MEASURE) begin
			if (col_pos == 0 && row_pos == 0)
				clear_tile_stats();
			if (in_grid) begin
				if (gray < tile_lo[slot])
					tile_lo[slot] = gray[7:0];
				if (gray > tile_hi[slot])
					tile_hi[slot] = gray[7:0];
			end
		end else begin
			v.dark = 1'b0;
			if (in_grid) begin
				mid = (int'(tile_lo[slot]) + int'(tile_hi[slot])) / 2;
				v.dark = gray < mid;
			end
			v.last_pixel = frame_end;
			verdict_q = {verdict_q, v};
		end
		if (row_end) begin
			col_pos = 0;
			col_in_tile = 0;
			tile_col = 0;
			if (frame_end) begin
				row_pos = 0;
				row_in_tile = 0;
				tile_row = 0;
			end else begin
				row_pos++;
				if (row_in_tile + 1 >= span_h) begin
					row_in_tile = 0;
					if (tile_row < GRID)
						tile_row++;
				end else begin
					row_in_tile++;
				end
			end
		end else begin
			col_pos++;
			if (col_in_tile + 1 >= span_w) begin
				col_in_tile = 0;
				if (tile_col < GRID)
					tile_col++;
			end else begin
				col_in_tile++;
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = tmb_pkg::FRAME_WIDTH_RESET;
			height_reg = tmb_pkg::FRAME_HEIGHT_RESET;
			col_pos = 0;
			row_pos = 0;
			col_in_tile = 0;
			tile_col = 0;
			row_in_tile = 0;
			tile_row = 0;
			clear_tile_stats();
			verdict_q.delete();
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (verdict_q.size() == 0) begin
					if (errors_seen < 10)
						$display("binarizer_checker: result word %0d arrived with none pending",
							words_checked);
					errors_seen++;
				end else begin
					want = verdict_q.pop_front();
					if (want.dark !== dark || want.last_pixel !== last_pixel) begin
						if (errors_seen < 10)
							$display("binarizer_checker: word %0d: expected %0b/%0b, got %0b/%0b",
								words_checked, want.dark, want.last_pixel, dark, last_pixel);
						errors_seen++;
					end
				end
				words_checked++;
			end
			if (in_valid && in_ready)
				binarize(operation, red, green, blue);
			if (cfg_we) begin
				if (cfg_index == tmb_pkg::REG_FRAME_WIDTH)
					width_reg = cfg_data;
				else if (cfg_index == tmb_pkg::REG_FRAME_HEIGHT)
					height_reg = cfg_data;
			end
			outstanding <= verdict_q.size();
		end
	end

endmodule

FILE: bench/tb_tiled_midpoint_binarizer_unit.sv
// Testbench top for the tiled midpoint binarizer: clock, reset, pixel stimulus and verdict.
module tb_tiled_midpoint_binarizer_unit;

	localparam int PIXEL_TARGET   = 1800;
	localparam int WATCHDOG_LIMIT = 400;
	localparam int DRAIN_SLACK    = 12;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [tmb_pkg::CFG_INDEX_W-1:0] cfg_index = tmb_pkg::REG_FRAME_WIDTH;
	logic [tmb_pkg::CFG_WIDTH-1:0]   cfg_data = '0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic                            operation = tmb_pkg::OP_MEASURE;
	logic [7:0]                      red = '0;
	logic [7:0]                      green = '0;
	logic [7:0]                      blue = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic                            dark;
	logic                            last_pixel;
	int                              mismatches;
	int                              outstanding;
	int                              pixels_sent = 0;
	int                              gap_pct = 0;
	int                              stall_pct = 0;
	int                              stall_left = 0;
	int                              quiet_cycles = 0;

	tiled_midpoint_binarizer_unit #(
		.TILES_PER_SIDE(4),
		.MAX_SIDE(4096)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.red(red),
		.green(green),
		.blue(blue),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.dark(dark),
		.last_pixel(last_pixel)
	);

	binarizer_checker #(
		.GRID(4),
		.SIDE_LIMIT(4096)
	) watch (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.red(red),
		.green(green),
		.blue(blue),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.dark(dark),
		.last_pixel(last_pixel),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(99) < stall_pct) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(12);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_tiled_midpoint_binarizer_unit: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [7:0] tint(int mode, logic [7:0] base);
		int v;
		case (mode)
			0: v = $urandom_range(255);
			1: v = int'(base) + int'($urandom_range(12)) - 6;
			2: v = $urandom_range(1) ? 255 : 0;
			default: v = base;
		endcase
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v[7:0];
	endfunction

	task automatic push_pixel(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		if ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(13, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		red <= r;
		green <= g;
		blue <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pixels_sent++;
	endtask

	task automatic send_pass(logic op, int count);
		int mode;
		logic [7:0] base;
		mode = $urandom_range(3);
		base = 8'($urandom_range(255));
		repeat (count) push_pixel(op, tint(mode, base), tint(mode, base), tint(mode, base));
	endtask

	task automatic send_noise(int count);
		repeat (count)
			push_pixel(1'($urandom_range(1)), tint(0, 8'h00), tint(0, 8'h00), tint(0, 8'h00));
	endtask

	// hold the sender until every result word is back and the pipeline is empty
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic set_frame(logic [tmb_pkg::CFG_WIDTH-1:0] w, logic [tmb_pkg::CFG_WIDTH-1:0] h);
		cfg_we <= 1'b1;
		cfg_index <= tmb_pkg::REG_FRAME_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= tmb_pkg::REG_FRAME_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// a 1x1 frame wraps the position counters on any pixel
	task automatic start_frame(logic [tmb_pkg::CFG_WIDTH-1:0] w,
			logic [tmb_pkg::CFG_WIDTH-1:0] h);
		drain();
		set_frame(13'd1, 13'd1);
		push_pixel(tmb_pkg::OP_MEASURE, tint(0, 8'h00), tint(0, 8'h00), tint(0, 8'h00));
		drain();
		set_frame(w, h);
	endtask

	initial begin
		int w;
		int h;
		int kind;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_pixel(tmb_pkg::OP_THRESHOLD, 8'hff, 8'hff, 8'hff);
		push_pixel(tmb_pkg::OP_THRESHOLD, 8'h00, 8'h00, 8'h00);
		push_pixel(tmb_pkg::OP_THRESHOLD, 8'd128, 8'd127, 8'd126);

		start_frame(13'd0, 13'h1fff);
		push_pixel(tmb_pkg::OP_MEASURE, 8'hff, 8'hff, 8'hff);
		push_pixel(tmb_pkg::OP_THRESHOLD, 8'h00, 8'h00, 8'h00);

		start_frame(13'd4, 13'd4);
		push_pixel(tmb_pkg::OP_MEASURE, 8'h00, 8'h00, 8'h00);
		push_pixel(tmb_pkg::OP_MEASURE, 8'hff, 8'hff, 8'hff);
		push_pixel(tmb_pkg::OP_MEASURE, 8'h00, 8'hff, 8'h00);
		push_pixel(tmb_pkg::OP_MEASURE, 8'hff, 8'h00, 8'hff);
		push_pixel(tmb_pkg::OP_THRESHOLD, 8'd100, 8'd100, 8'd100);
		drain();
		set_frame(13'd2, 13'd4);
		push_pixel(tmb_pkg::OP_THRESHOLD, 8'd40, 8'd200, 8'd90);
		push_pixel(tmb_pkg::OP_THRESHOLD, 8'd10, 8'd20, 8'd30);

		drain();
		set_frame(13'd1, 13'd1);
		push_pixel(tmb_pkg::OP_MEASURE, 8'h00, 8'h00, 8'h00);
		push_pixel(tmb_pkg::OP_THRESHOLD, 8'hff, 8'hff, 8'hff);

		start_frame(13'd4096, 13'd4);
		push_pixel(tmb_pkg::OP_MEASURE, 8'h55, 8'haa, 8'h55);
		push_pixel(tmb_pkg::OP_THRESHOLD, 8'haa, 8'h55, 8'haa);

		while (pixels_sent < PIXEL_TARGET) begin
			if (pixels_sent >= PIXEL_TARGET * 4 / 5) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				case ($urandom_range(2))
					0: gap_pct = 0;
					1: gap_pct = 15;
					default: gap_pct = 40;
				endcase
				case ($urandom_range(2))
					0: stall_pct = 0;
					1: stall_pct = 15;
					default: stall_pct = 40;
				endcase
			end
			kind = $urandom_range(99);
			if (kind < 6) begin
				case ($urandom_range(3))
					0: w = 4096;
					1: w = 0;
					2: w = 8191;
					default: w = $urandom_range(4097, 2048);
				endcase
				h = $urandom_range(1) ? $urandom_range(12, 1) : 4096;
				start_frame(13'(w), 13'(h));
				send_pass(tmb_pkg::OP_MEASURE, $urandom_range(60, 20));
				send_pass(tmb_pkg::OP_THRESHOLD, $urandom_range(60, 20));
			end else if (kind < 22) begin
				w = $urandom_range(12, 1);
				h = $urandom_range(12, 1);
				start_frame(13'(w), 13'(h));
				send_noise($urandom_range(2 * w * h, 1));
				if ($urandom_range(1)) begin
					drain();
					set_frame(13'($urandom_range(12, 1)), 13'($urandom_range(12, 1)));
					send_noise($urandom_range(40, 1));
				end
			end else begin
				w = ($urandom_range(4) == 0) ? $urandom_range(3, 1) : $urandom_range(12, 4);
				h = ($urandom_range(4) == 0) ? $urandom_range(3, 1) : $urandom_range(12, 4);
				start_frame(13'(w), 13'(h));
				if ($urandom_range(4) == 0)
					send_pass(tmb_pkg::OP_THRESHOLD, w * h);
				send_pass(tmb_pkg::OP_MEASURE, w * h);
				repeat ($urandom_range(2, 1)) send_pass(tmb_pkg::OP_THRESHOLD, w * h);
			end
		end

		drain();
		if (mismatches == 0 && outstanding == 0)
			$display("tb_tiled_midpoint_binarizer_unit: clean");
		else
			$display("tb_tiled_midpoint_binarizer_unit: errors");
		$finish;
	end

endmodule
